FILE: hdl/nec_ir_pkg.sv
package nec_ir_pkg;

    localparam int WIDTH_W = 14;
    localparam int BYTE_W  = 8;
    localparam int TICK_W  = 4;
    localparam int WORD_W  = 32;

    localparam logic [WIDTH_W-1:0] ZERO_LO = 14'd300;
    localparam logic [WIDTH_W-1:0] ZERO_HI = 14'd800;
    localparam logic [WIDTH_W-1:0] ONE_LO  = 14'd1400;
    localparam logic [WIDTH_W-1:0] ONE_HI  = 14'd1800;
    localparam logic [WIDTH_W-1:0] REP_LO  = 14'd2200;
    localparam logic [WIDTH_W-1:0] REP_HI  = 14'd2600;
    localparam logic [WIDTH_W-1:0] LEAD_LO = 14'd4200;
    localparam logic [WIDTH_W-1:0] LEAD_HI = 14'd4700;

    localparam logic [TICK_W-1:0] TICK_LIMIT = 4'd14;

    localparam logic [BYTE_W-1:0] PRIMARY_RESET   = 8'h00;
    localparam logic [BYTE_W-1:0] ALTERNATE_RESET = 8'h08;

    typedef enum logic [1:0] {
        FUNC_RISE = 2'd0,
        FUNC_FALL = 2'd1,
        FUNC_TICK = 2'd2,
        FUNC_SCAN = 2'd3
    } func_t;

    typedef enum logic {
        REG_PRIMARY   = 1'b0,
        REG_ALTERNATE = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic zero_bit;
        logic one_bit;
        logic repeat_code;
        logic leader;
    } width_class_t;

endpackage

FILE: hdl/nec_ir_width_class.sv
module nec_ir_width_class (
    input  logic [nec_ir_pkg::WIDTH_W-1:0] pulse_width,
    output nec_ir_pkg::width_class_t       width_class
);
    import nec_ir_pkg::*;

    // Every window is open at both ends.
    always_comb begin
        width_class.zero_bit    = (pulse_width > ZERO_LO) && (pulse_width < ZERO_HI);
        width_class.one_bit     = (pulse_width > ONE_LO)  && (pulse_width < ONE_HI);
        width_class.repeat_code = (pulse_width > REP_LO)  && (pulse_width < REP_HI);
        width_class.leader      = (pulse_width > LEAD_LO) && (pulse_width < LEAD_HI);
    end

endmodule

FILE: hdl/nec_ir_frame_decoder.sv
// NEC infrared frame decoder driven by edge, tick and scan events. Every accepted
// event yields exactly one result beat carrying the key code (nonzero only on a
// valid scan), the repeat count and the receiving flag as they stand after the
// event. One event is accepted per clock cycle while s_ready is high; its result
// is registered in a two-entry output stage (result register plus skid register)
// that lets the input keep accepting while one result waits, so s_ready drops
// only when both entries are full. The user must write addresses through the
// configuration port only while the block is idle; the block does not enforce it.
module nec_ir_frame_decoder (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [nec_ir_pkg::BYTE_W-1:0]  cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_func,
    input  logic [nec_ir_pkg::WIDTH_W-1:0] s_pulse_width,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [nec_ir_pkg::BYTE_W-1:0]  m_key_code,
    output logic [nec_ir_pkg::BYTE_W-1:0]  m_repeat_count,
    output logic                           m_receiving
);
    import nec_ir_pkg::*;

    logic [BYTE_W-1:0] primary_reg;
    logic [BYTE_W-1:0] alternate_reg;

    logic              frame_active_reg, frame_active_next;
    logic              data_ready_reg,   data_ready_next;
    logic              high_seen_reg,    high_seen_next;
    logic [TICK_W-1:0] tick_count_reg,   tick_count_next;
    logic [WORD_W-1:0] shift_word_reg,   shift_word_next;
    logic [BYTE_W-1:0] repeats_reg,      repeats_next;
    logic [BYTE_W-1:0] key_next;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_key_reg;
    logic [BYTE_W-1:0] out_rep_reg;
    logic              out_recv_reg;
    logic              skid_valid_reg;
    logic [BYTE_W-1:0] skid_key_reg;
    logic [BYTE_W-1:0] skid_rep_reg;
    logic              skid_recv_reg;

    width_class_t      width_class;
    func_t             func;
    logic              accept;
    logic              pop;
    logic [BYTE_W-1:0] addr, addr_n, cmd, cmd_n;
    logic [BYTE_W-1:0] scan_result;

    nec_ir_width_class u_width_class (
        .pulse_width (s_pulse_width),
        .width_class (width_class)
    );

    assign func    = func_t'(s_func);
    assign accept  = s_valid && s_ready;
    assign pop     = out_valid_reg && m_ready;
    assign s_ready = !skid_valid_reg;

    assign m_valid        = out_valid_reg;
    assign m_key_code     = out_key_reg;
    assign m_repeat_count = out_rep_reg;
    assign m_receiving    = out_recv_reg;

    assign addr   = shift_word_reg[31:24];
    assign addr_n = shift_word_reg[23:16];
    assign cmd    = shift_word_reg[15:8];
    assign cmd_n  = shift_word_reg[7:0];

    always_comb begin
        scan_result = '0;
        if ((addr == ~addr_n) && ((addr == primary_reg) || (addr == alternate_reg))
            && (cmd == ~cmd_n)) begin
            scan_result = cmd;
        end
    end

    always_comb begin
        frame_active_next = frame_active_reg;
        data_ready_next   = data_ready_reg;
        high_seen_next    = high_seen_reg;
        tick_count_next   = tick_count_reg;
        shift_word_next   = shift_word_reg;
        repeats_next      = repeats_reg;
        key_next          = '0;
        unique case (func)
            FUNC_RISE: begin
                high_seen_next = 1'b1;
            end
            FUNC_FALL: begin
                high_seen_next = 1'b0;
                if (high_seen_reg) begin
                    if (frame_active_reg) begin
                        if (width_class.zero_bit) begin
                            shift_word_next = {shift_word_reg[WORD_W-2:0], 1'b0};
                        end else if (width_class.one_bit) begin
                            shift_word_next = {shift_word_reg[WORD_W-2:0], 1'b1};
                        end else if (width_class.repeat_code) begin
                            repeats_next    = repeats_reg + 8'd1;
                            tick_count_next = '0;
                        end
                    end else if (width_class.leader) begin
                        frame_active_next = 1'b1;
                        repeats_next      = '0;
                    end
                end
            end
            FUNC_TICK: begin
                if (frame_active_reg) begin
                    high_seen_next = 1'b0;
                    if (tick_count_reg == '0) begin
                        data_ready_next = 1'b1;
                    end
                    if (tick_count_reg < TICK_LIMIT) begin
                        tick_count_next = tick_count_reg + 4'd1;
                    end else begin
                        frame_active_next = 1'b0;
                        tick_count_next   = '0;
                    end
                end
            end
            FUNC_SCAN: begin
                if (data_ready_reg) begin
                    key_next = scan_result;
                    if ((scan_result == '0) || !frame_active_reg) begin
                        data_ready_next = 1'b0;
                        repeats_next    = '0;
                    end
                end
            end
            default: begin
                high_seen_next = high_seen_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primary_reg      <= PRIMARY_RESET;
            alternate_reg    <= ALTERNATE_RESET;
            frame_active_reg <= 1'b0;
            data_ready_reg   <= 1'b0;
            high_seen_reg    <= 1'b0;
            tick_count_reg   <= '0;
            shift_word_reg   <= '0;
            repeats_reg      <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_PRIMARY:   primary_reg   <= cfg_data;
                    REG_ALTERNATE: alternate_reg <= cfg_data;
                    default:       primary_reg   <= primary_reg;
                endcase
            end
            if (accept) begin
                frame_active_reg <= frame_active_next;
                data_ready_reg   <= data_ready_next;
                high_seen_reg    <= high_seen_next;
                tick_count_reg   <= tick_count_next;
                shift_word_reg   <= shift_word_next;
                repeats_reg      <= repeats_next;
            end
        end
    end

    // A new beat goes to the result register when it is free or being drained,
    // otherwise it parks in the skid register until the result register empties.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (accept) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_key_reg  <= skid_key_reg;
                out_rep_reg  <= skid_rep_reg;
                out_recv_reg <= skid_recv_reg;
            end
        end else if (accept) begin
            if (!out_valid_reg || pop) begin
                out_key_reg  <= key_next;
                out_rep_reg  <= repeats_next;
                out_recv_reg <= frame_active_next;
            end else begin
                skid_key_reg  <= key_next;
                skid_rep_reg  <= repeats_next;
                skid_recv_reg <= frame_active_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a beat while the result register is empty");

    a_tick_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_count_reg <= TICK_LIMIT)
        else $error("tick count passed its limit");

    a_frame_start_clears_repeats: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(frame_active_reg) |-> (repeats_reg == '0))
        else $error("frame started with a nonzero repeat count");

    a_rise_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (func == FUNC_RISE)) |=> high_seen_reg)
        else $error("rising edge event did not arm the high-level flag");

    a_scan_idle_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (func == FUNC_SCAN) && !data_ready_reg) |-> (key_next == '0))
        else $error("scan without data ready produced a key code");
`endif

endmodule

FILE: test/nec_ir_decode_checker.sv
module nec_ir_decode_checker import nec_ir_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [1:0]           s_func,
    input  logic [WIDTH_W-1:0]   s_pulse_width,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [BYTE_W-1:0]    m_key_code,
    input  logic [BYTE_W-1:0]    m_repeat_count,
    input  logic                 m_receiving,
    output int                   failures,
    output int                   pending,
    output int                   checked,
    output int                   keys_found
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [BYTE_W-1:0] key_code;
        logic [BYTE_W-1:0] repeat_count;
        logic              receiving;
    } ir_report_t;

    logic [BYTE_W-1:0] addr_primary   = PRIMARY_RESET;
    logic [BYTE_W-1:0] addr_alternate = ALTERNATE_RESET;
    logic              frame_on       = 1'b0;
    logic              ready_flag     = 1'b0;
    logic              high_flag      = 1'b0;
    logic [TICK_W-1:0] tick_cnt       = '0;
    logic [WORD_W-1:0] code_word      = '0;
    logic [BYTE_W-1:0] repeat_cnt     = '0;

    ir_report_t expected_reports[$];
    int errors   = 0;
    int n_checked = 0;
    int n_keys   = 0;

    initial begin
        failures   = 0;
        pending    = 0;
        checked    = 0;
        keys_found = 0;
    end

    function automatic logic in_range(logic [WIDTH_W-1:0] w, logic [WIDTH_W-1:0] lo,
                                      logic [WIDTH_W-1:0] hi);
        return w > lo && w < hi;
    endfunction

    function automatic ir_report_t decode_event(func_t kind, logic [WIDTH_W-1:0] w);
        ir_report_t rpt;
        logic [BYTE_W-1:0] addr, addr_n, cmd, cmd_n;
        rpt.key_code = '0;
        case (kind)
            FUNC_RISE: high_flag = 1'b1;
            FUNC_FALL: begin
                if (high_flag) begin
                    if (frame_on) begin
                        if (in_range(w, ZERO_LO, ZERO_HI)) begin
                            code_word = {code_word[WORD_W-2:0], 1'b0};
                        end else if (in_range(w, ONE_LO, ONE_HI)) begin
                            code_word = {code_word[WORD_W-2:0], 1'b1};
                        end else if (in_range(w, REP_LO, REP_HI)) begin
                            repeat_cnt = repeat_cnt + 1'b1;
                            tick_cnt   = '0;
                        end
                    end else if (in_range(w, LEAD_LO, LEAD_HI)) begin
                        frame_on   = 1'b1;
                        repeat_cnt = '0;
                    end
                end
                high_flag = 1'b0;
            end
            FUNC_TICK: begin
                if (frame_on) begin
                    high_flag = 1'b0;
                    if (tick_cnt == '0) begin
                        ready_flag = 1'b1;
                    end
                    if (tick_cnt < TICK_LIMIT) begin
                        tick_cnt = tick_cnt + 1'b1;
                    end else begin
                        frame_on = 1'b0;
                        tick_cnt = '0;
                    end
                end
            end
            default: begin
                if (ready_flag) begin
                    {addr, addr_n, cmd, cmd_n} = code_word;
                    if (addr == ~addr_n && (addr == addr_primary || addr == addr_alternate)
                        && cmd == ~cmd_n) begin
                        rpt.key_code = cmd;
                    end
                    if (rpt.key_code == '0 || !frame_on) begin
                        ready_flag = 1'b0;
                        repeat_cnt = '0;
                    end
                end
            end
        endcase
        rpt.repeat_count = repeat_cnt;
        rpt.receiving    = frame_on;
        return rpt;
    endfunction

    always @(posedge aclk) begin
        ir_report_t want;
        if (!aresetn) begin
            addr_primary   = PRIMARY_RESET;
            addr_alternate = ALTERNATE_RESET;
            frame_on       = 1'b0;
            ready_flag     = 1'b0;
            high_flag      = 1'b0;
            tick_cnt       = '0;
            code_word      = '0;
            repeat_cnt     = '0;
            expected_reports.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_PRIMARY) begin
                    addr_primary = cfg_data;
                end else begin
                    addr_alternate = cfg_data;
                end
            end
            if (s_valid && s_ready) begin
                expected_reports.push_back(decode_event(func_t'(s_func), s_pulse_width));
            end
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    $error({"result beat with nothing expected: ",
                            "key_code %0d repeat_count %0d receiving %0d"},
                           m_key_code, m_repeat_count, m_receiving);
                    errors++;
                end else begin
                    want = expected_reports.pop_front();
                    n_checked++;
                    if (want.key_code != '0) begin
                        n_keys++;
                    end
                    if (m_key_code !== want.key_code) begin
                        $error("key_code: expected %0d, got %0d", want.key_code, m_key_code);
                        errors++;
                    end
                    if (m_repeat_count !== want.repeat_count) begin
                        $error("repeat_count: expected %0d, got %0d",
                               want.repeat_count, m_repeat_count);
                        errors++;
                    end
                    if (m_receiving !== want.receiving) begin
                        $error("receiving: expected %0d, got %0d", want.receiving, m_receiving);
                        errors++;
                    end
                end
            end
        end
        failures   <= errors;
        pending    <= expected_reports.size();
        checked    <= n_checked;
        keys_found <= n_keys;
    end

endmodule

FILE: test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nec_ir_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int ITEMS_PER_PHASE = 270;
    localparam int LONG_HOLD       = 80;

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    cfg_reg_t            cfg_index;
    logic [BYTE_W-1:0]   cfg_data;
    logic                s_valid;
    logic                s_ready;
    func_t               s_func;
    logic [WIDTH_W-1:0]  s_pulse_width;
    logic                m_valid;
    logic                m_ready;
    logic [BYTE_W-1:0]   m_key_code;
    logic [BYTE_W-1:0]   m_repeat_count;
    logic                m_receiving;

    int failures;
    int pending;
    int checked;
    int keys_found;

    int sent        = 0;
    int frames      = 0;
    int settings    = 1;
    int idle_cycles = 0;
    logic [BYTE_W-1:0] cur_primary   = PRIMARY_RESET;
    logic [BYTE_W-1:0] cur_alternate = ALTERNATE_RESET;
    bit calm    = 1'b0;
    bit hold_go = 1'b0;

    nec_ir_frame_decoder u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_pulse_width  (s_pulse_width),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_key_code     (m_key_code),
        .m_repeat_count (m_repeat_count),
        .m_receiving    (m_receiving)
    );

    nec_ir_decode_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_pulse_width  (s_pulse_width),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_key_code     (m_key_code),
        .m_repeat_count (m_repeat_count),
        .m_receiving    (m_receiving),
        .failures       (failures),
        .pending        (pending),
        .checked        (checked),
        .keys_found     (keys_found)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("Verification failed");
        $finish;
    end

    initial begin : result_sink
        bit hold_taken;
        hold_taken = 1'b0;
        m_ready = 1'b0;
        forever begin
            if (hold_go && !hold_taken) begin
                hold_taken = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_event(func_t kind, logic [WIDTH_W-1:0] w);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= kind;
        s_pulse_width <= w;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    function automatic logic [WIDTH_W-1:0] any_width();
        return WIDTH_W'($urandom_range(0, 16383));
    endfunction

    task automatic pulse(logic [WIDTH_W-1:0] w);
        send_event(FUNC_RISE, any_width());
        send_event(FUNC_FALL, w);
    endtask

    function automatic logic [WIDTH_W-1:0] window_width(logic [WIDTH_W-1:0] lo,
                                                        logic [WIDTH_W-1:0] hi);
        return WIDTH_W'($urandom_range(lo + 1, hi - 1));
    endfunction

    // A width on or right next to one of the window limits.
    function automatic logic [WIDTH_W-1:0] border_width();
        logic [WIDTH_W-1:0] b;
        case ($urandom_range(0, 7))
            0: b = ZERO_LO;
            1: b = ZERO_HI;
            2: b = ONE_LO;
            3: b = ONE_HI;
            4: b = REP_LO;
            5: b = REP_HI;
            6: b = LEAD_LO;
            default: b = LEAD_HI;
        endcase
        return WIDTH_W'(b + $urandom_range(0, 2) - 1);
    endfunction

    task automatic noise();
        send_event(func_t'($urandom_range(0, 3)),
                   $urandom_range(0, 1) ? any_width() : border_width());
    endtask

    task automatic send_frame();
        logic [WORD_W-1:0] frame_bits;
        logic [BYTE_W-1:0] addr, cmd;
        int steps, pick;
        case ($urandom_range(0, 4))
            0, 1: addr = cur_primary;
            2, 3: addr = cur_alternate;
            default: addr = BYTE_W'($urandom);
        endcase
        cmd = BYTE_W'($urandom);
        frame_bits = {addr, ~addr, cmd, ~cmd};
        if ($urandom_range(0, 7) == 0) begin
            frame_bits[23:16] = BYTE_W'($urandom);
        end
        if ($urandom_range(0, 7) == 0) begin
            frame_bits[7:0] = BYTE_W'($urandom);
        end
        // Fifteen ticks always close a frame that is still open.
        if ($urandom_range(0, 1) == 1) begin
            repeat (15) send_event(FUNC_TICK, any_width());
        end
        pulse($urandom_range(0, 9) == 0 ? border_width() : window_width(LEAD_LO, LEAD_HI));
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if ($urandom_range(0, 39) == 0) begin
                noise();
            end
            pulse(frame_bits[i] ? window_width(ONE_LO, ONE_HI) : window_width(ZERO_LO, ZERO_HI));
        end
        steps = $urandom_range(4, 24);
        repeat (steps) begin
            pick = $urandom_range(0, 19);
            if (pick < 9) begin
                send_event(FUNC_TICK, any_width());
            end else if (pick < 14) begin
                send_event(FUNC_SCAN, any_width());
            end else if (pick < 17) begin
                pulse(window_width(REP_LO, REP_HI));
            end else begin
                noise();
            end
        end
        frames++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic set_addresses(logic [BYTE_W-1:0] primary, logic [BYTE_W-1:0] alternate);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PRIMARY;
        cfg_data  <= primary;
        @(posedge aclk);
        cfg_index <= REG_ALTERNATE;
        cfg_data  <= alternate;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cur_primary   = primary;
        cur_alternate = alternate;
        settings++;
    endtask

    initial begin : stimulus
        int target;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_PRIMARY;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_func        = FUNC_RISE;
        s_pulse_width = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_event(FUNC_SCAN, 14'h3FFF);
        send_event(FUNC_TICK, '0);
        send_event(FUNC_FALL, 14'd4500);
        pulse(LEAD_LO);
        pulse(14'h3FFF);
        pulse(LEAD_HI);
        pulse(LEAD_LO + 1'b1);
        pulse(ZERO_LO);
        pulse(ZERO_LO + 1'b1);
        pulse(ONE_HI - 1'b1);
        pulse(REP_HI - 1'b1);
        send_event(FUNC_FALL, 14'd2300);
        pulse(14'd10000);
        send_event(FUNC_TICK, '0);
        send_event(FUNC_SCAN, '0);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: ;
                1: set_addresses(8'hFF, 8'h00);
                2: set_addresses(8'h00, 8'hFF);
                default: set_addresses(BYTE_W'($urandom), BYTE_W'($urandom));
            endcase
            if (phase == 1) begin
                hold_go = 1'b1;
            end
            calm   = (phase == 5);
            target = sent + ITEMS_PER_PHASE;
            while (sent < target) send_frame();
            drain();
        end
        repeat (10) @(posedge aclk);

        $display("Summary: %0d events, %0d generated frames, %0d address settings.",
                 sent, frames, settings);
        $display("Summary: %0d result beats compared, %0d scans returned a key code.",
                 checked, keys_found);
        if (failures == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
